// ----- hdl/spdma_pkg.sv -----
// Shared types and constants for the sprite page DMA controller.
`timescale 1ns / 1ps
`default_nettype none

package spdma_pkg;

    localparam logic [4:0]  DMA_REG_OFFSET   = 5'h14;
    localparam logic [15:0] SPRITE_DATA_PORT = 16'h2004;

    typedef enum logic {
        ACT_TICK  = 1'b0,
        ACT_WRITE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        BUS_OP_NONE  = 2'd0,
        BUS_OP_READ  = 2'd1,
        BUS_OP_WRITE = 2'd2
    } t_bus_op;

    typedef enum logic [1:0] {
        ST_CLEAR     = 2'd0,
        ST_PENDING   = 2'd1,
        ST_COMMITTED = 2'd2,
        ST_SERVICED  = 2'd3
    } t_xfer_state;

    typedef struct packed {
        logic       action;
        logic [4:0] reg_offset;
        logic [7:0] write_data;
        logic       cpu_suspended;
        logic       cpu_reset_pending;
        logic       cpu_reset_active;
        logic [7:0] bus_read_data;
    } t_in_item;

    typedef struct packed {
        logic [15:0] bus_address;
        logic [1:0]  bus_op;
        logic [7:0]  bus_write_data;
        logic        dma_busy;
        logic        ready_line;
        logic        reg_handled;
    } t_out_item;

    typedef struct packed {
        t_xfer_state xfer_state;
        logic [7:0]  source_page;
        logic [7:0]  byte_index;
        logic        put_phase;
        logic        ready_flag;
        logic [7:0]  data_latch;
    } t_dma_state;

    localparam t_dma_state DMA_STATE_RESET = '{
        xfer_state:  ST_CLEAR,
        source_page: 8'd0,
        byte_index:  8'd0,
        put_phase:   1'b0,
        ready_flag:  1'b1,
        data_latch:  8'd0
    };

endpackage

`default_nettype wire

// ----- hdl/spdma_in_if.sv -----
// Input channel: one tick or register write per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface spdma_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [4:0] reg_offset;
    logic [7:0] write_data;
    logic       cpu_suspended;
    logic       cpu_reset_pending;
    logic       cpu_reset_active;
    logic [7:0] bus_read_data;

    modport source (
        output valid, action, reg_offset, write_data, cpu_suspended,
               cpu_reset_pending, cpu_reset_active, bus_read_data,
        input  ready
    );

    modport sink (
        input  valid, action, reg_offset, write_data, cpu_suspended,
               cpu_reset_pending, cpu_reset_active, bus_read_data,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/spdma_out_if.sv -----
// Output channel: one bus/status result per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface spdma_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] bus_address;
    logic [1:0]  bus_op;
    logic [7:0]  bus_write_data;
    logic        dma_busy;
    logic        ready_line;
    logic        reg_handled;

    modport source (
        output valid, bus_address, bus_op, bus_write_data, dma_busy,
               ready_line, reg_handled,
        input  ready
    );

    modport sink (
        input  valid, bus_address, bus_op, bus_write_data, dma_busy,
               ready_line, reg_handled,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/sprite_page_dma_controller_unit.sv -----
// Top level of the sprite page DMA controller.
`timescale 1ns / 1ps
`default_nettype none

// Sprite page DMA controller. Each transfer on i_in is either a CPU clock tick
// or a register write; each yields exactly one result on o_out describing the
// bus access for that tick (address, read/write/none, write data), whether
// DMA used the tick, the ready line to the CPU and whether a register write
// hit the DMA register at offset 0x14. The block takes one transfer per clock
// cycle with no bubbles: an input register feeds a single stage of step logic
// that updates the engine state and loads the result register, so a result
// is presented on o_out once its input has passed through both registers.
// Both registers advance together whenever the result register is empty or
// being drained, so back-pressure on o_out stalls i_in for only as long as the
// output is held.
module sprite_page_dma_controller_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    spdma_in_if.sink   i_in,
    spdma_out_if.source o_out
);
    import spdma_pkg::*;

    // input register
    logic       r_in_valid;
    t_in_item   r_in_item;
    // engine state, advanced once per item processed
    t_dma_state r_state;
    t_dma_state n_state;
    // result register
    logic       r_out_valid;
    t_out_item  r_out_item;
    t_out_item  n_out_item;

    logic out_load;   // result register can take a new result
    logic step_fire;  // input register item is processed this cycle
    logic in_take;    // transfer accepted on i_in

    assign out_load  = !r_out_valid || o_out.ready;
    assign step_fire = r_in_valid && out_load;
    assign i_in.ready = !r_in_valid || out_load;
    assign in_take   = i_in.valid && i_in.ready;

    spdma_step u_step (
        .i_item   (r_in_item),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_out_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= DMA_STATE_RESET;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
            if (step_fire) begin
                r_state <= n_state;
            end
        end
        if (in_take) begin
            r_in_item.action            <= i_in.action;
            r_in_item.reg_offset        <= i_in.reg_offset;
            r_in_item.write_data        <= i_in.write_data;
            r_in_item.cpu_suspended     <= i_in.cpu_suspended;
            r_in_item.cpu_reset_pending <= i_in.cpu_reset_pending;
            r_in_item.cpu_reset_active  <= i_in.cpu_reset_active;
            r_in_item.bus_read_data     <= i_in.bus_read_data;
        end
        if (step_fire) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.bus_address    = r_out_item.bus_address;
    assign o_out.bus_op         = r_out_item.bus_op;
    assign o_out.bus_write_data = r_out_item.bus_write_data;
    assign o_out.dma_busy       = r_out_item.dma_busy;
    assign o_out.ready_line     = r_out_item.ready_line;
    assign o_out.reg_handled    = r_out_item.reg_handled;

endmodule

`default_nettype wire

// ----- hdl/spdma_step.sv -----
// Next-state and result logic for one DMA tick or register write.
`timescale 1ns / 1ps
`default_nettype none

module spdma_step (
    input  spdma_pkg::t_in_item   i_item,
    input  spdma_pkg::t_dma_state i_state,
    output spdma_pkg::t_dma_state o_state,
    output spdma_pkg::t_out_item  o_result
);
    import spdma_pkg::*;

    t_dma_state s;
    t_out_item  res;
    logic [7:0] idx_inc;

    always_comb begin
        s       = i_state;
        res     = '0;
        idx_inc = i_state.byte_index + 8'd1;

        if (t_action'(i_item.action) == ACT_WRITE) begin
            if (i_item.reg_offset == DMA_REG_OFFSET) begin
                s.source_page   = i_item.write_data;
                s.byte_index    = 8'd0;
                s.xfer_state    = ST_PENDING;
                res.reg_handled = 1'b1;
            end
        end else if (!i_item.cpu_reset_pending) begin
            if (i_item.cpu_reset_active) begin
                s.byte_index = 8'd0;
                s.xfer_state = ST_CLEAR;
            end
            idx_inc = s.byte_index + 8'd1;
            if (i_item.cpu_suspended) begin
                unique case (s.xfer_state)
                    ST_PENDING: begin
                        if (!s.put_phase) begin
                            res.bus_address = {s.source_page, s.byte_index};
                            res.bus_op      = BUS_OP_READ;
                            s.data_latch    = i_item.bus_read_data;
                            s.xfer_state    = ST_COMMITTED;
                        end
                        res.dma_busy = 1'b1;
                    end
                    ST_COMMITTED: begin
                        if (s.put_phase) begin
                            res.bus_address    = SPRITE_DATA_PORT;
                            res.bus_op         = BUS_OP_WRITE;
                            res.bus_write_data = s.data_latch;
                            s.byte_index       = idx_inc;
                            // wrap of the index marks the last byte
                            s.xfer_state = (idx_inc != 8'd0) ? ST_PENDING : ST_SERVICED;
                        end
                        res.dma_busy = 1'b1;
                    end
                    ST_SERVICED: s.xfer_state = ST_CLEAR;
                    ST_CLEAR:    ;
                    default:     ;
                endcase
            end
            s.ready_flag = (s.xfer_state == ST_CLEAR);
            s.put_phase  = ~s.put_phase;
        end

        res.ready_line = s.ready_flag;
    end

    assign o_state  = s;
    assign o_result = res;

endmodule

`default_nettype wire

// ----- tb/sv/sprite_page_dma_controller_unit_tb.sv -----
// Testbench for the sprite page DMA controller: predicted bus accesses vs. block results.
`timescale 1ns / 1ps

module sprite_page_dma_controller_unit_tb;
    import spdma_pkg::*;

    // Tracks the engine state and holds the bus accesses still due from the block.
    class dma_bus_scoreboard;
        t_xfer_state xfer;
        logic [7:0]  page;
        logic [7:0]  idx;
        logic [7:0]  latch;
        logic        phase;
        logic        rdy;
        t_out_item   bus_access_q[$];
        int          mismatch_count;
        int          result_count;

        function new();
            xfer           = ST_CLEAR;
            page           = 8'd0;
            idx            = 8'd0;
            latch          = 8'd0;
            phase          = 1'b0;
            rdy            = 1'b1;
            mismatch_count = 0;
            result_count   = 0;
        endfunction

        function int pending();
            return bus_access_q.size();
        endfunction

        task flag_mismatch(input string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatch_count++;
        endtask

        // Advance the engine by one accepted transfer and queue the bus access it yields.
        function void predict_bus_access(input t_in_item it);
            t_out_item r;
            r = '0;
            if (it.action == ACT_WRITE) begin
                if (it.reg_offset == DMA_REG_OFFSET) begin
                    page          = it.write_data;
                    idx           = 8'd0;
                    xfer          = ST_PENDING;
                    r.reg_handled = 1'b1;
                end
            end else if (!it.cpu_reset_pending) begin
                if (it.cpu_reset_active) begin
                    idx  = 8'd0;
                    xfer = ST_CLEAR;
                    rdy  = 1'b1;
                end
                if (it.cpu_suspended) begin
                    case (xfer)
                        ST_PENDING: begin
                            if (!phase) begin
                                r.bus_address = {page, idx};
                                r.bus_op      = BUS_OP_READ;
                                latch         = it.bus_read_data;
                                xfer          = ST_COMMITTED;
                            end
                            r.dma_busy = 1'b1;
                        end
                        ST_COMMITTED: begin
                            if (phase) begin
                                r.bus_address    = SPRITE_DATA_PORT;
                                r.bus_op         = BUS_OP_WRITE;
                                r.bus_write_data = latch;
                                idx              = idx + 8'd1;
                                xfer             = (idx != 8'd0) ? ST_PENDING : ST_SERVICED;
                            end
                            r.dma_busy = 1'b1;
                        end
                        ST_SERVICED: xfer = ST_CLEAR;
                        default: ;
                    endcase
                end
                rdy   = (xfer == ST_CLEAR);
                phase = ~phase;
            end
            r.ready_line = rdy;
            bus_access_q.push_back(r);
        endfunction

        task check_bus_access(input t_out_item got);
            t_out_item want;
            result_count++;
            if (bus_access_q.size() == 0) begin
                flag_mismatch($sformatf("result %0d arrived with nothing expected", result_count));
            end else begin
                want = bus_access_q.pop_front();
                if (got.bus_address !== want.bus_address)
                    flag_mismatch($sformatf("result %0d bus_address got %h want %h",
                        result_count, got.bus_address, want.bus_address));
                if (got.bus_op !== want.bus_op)
                    flag_mismatch($sformatf("result %0d bus_op got %0d want %0d",
                        result_count, got.bus_op, want.bus_op));
                if (got.bus_write_data !== want.bus_write_data)
                    flag_mismatch($sformatf("result %0d bus_write_data got %h want %h",
                        result_count, got.bus_write_data, want.bus_write_data));
                if (got.dma_busy !== want.dma_busy)
                    flag_mismatch($sformatf("result %0d dma_busy got %b want %b",
                        result_count, got.dma_busy, want.dma_busy));
                if (got.ready_line !== want.ready_line)
                    flag_mismatch($sformatf("result %0d ready_line got %b want %b",
                        result_count, got.ready_line, want.ready_line));
                if (got.reg_handled !== want.reg_handled)
                    flag_mismatch($sformatf("result %0d reg_handled got %b want %b",
                        result_count, got.reg_handled, want.reg_handled));
            end
        endtask
    endclass

    localparam int RANDOM_ITEMS = 950;

    logic i_clk;
    logic i_rst_n;

    spdma_in_if  in_ch ();
    spdma_out_if out_ch ();

    sprite_page_dma_controller_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    dma_bus_scoreboard sb;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int n_sent      = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Result side: check on each accepted transfer, stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            sb.check_bus_access('{bus_address: out_ch.bus_address, bus_op: out_ch.bus_op,
                                  bus_write_data: out_ch.bus_write_data,
                                  dma_busy: out_ch.dma_busy, ready_line: out_ch.ready_line,
                                  reg_handled: out_ch.reg_handled});
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Tick with the unused register fields randomized.
    function automatic t_in_item mk_tick(input logic susp, input logic rst_pend,
                                         input logic rst_act, input logic [7:0] rdata);
        t_in_item it;
        it                   = t_in_item'($urandom);
        it.action            = ACT_TICK;
        it.cpu_suspended     = susp;
        it.cpu_reset_pending = rst_pend;
        it.cpu_reset_active  = rst_act;
        it.bus_read_data     = rdata;
        return it;
    endfunction

    function automatic t_in_item mk_write(input logic [4:0] offset, input logic [7:0] data);
        t_in_item it;
        it            = t_in_item'($urandom);
        it.action     = ACT_WRITE;
        it.reg_offset = offset;
        it.write_data = data;
        return it;
    endfunction

    // Mostly a clean copy tick, now and then an unsuspended CPU or a CPU reset.
    function automatic t_in_item rand_tick();
        return mk_tick($urandom_range(0, 99) < 85, $urandom_range(0, 99) < 4,
                       $urandom_range(0, 99) < 3, 8'($urandom));
    endfunction

    // Called at a clock edge; returns at the edge where the transfer is taken.
    task automatic send_item(input t_in_item it);
        // idle mix: receiver-heavy gaps, then sender-heavy, then none
        if (n_sent < 320) begin
            tx_idle_pct = 20;
            rx_idle_pct = 71;
        end else if (n_sent < 640) begin
            tx_idle_pct = 71;
            rx_idle_pct = 20;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid             <= 1'b1;
        in_ch.action            <= it.action;
        in_ch.reg_offset        <= it.reg_offset;
        in_ch.write_data        <= it.write_data;
        in_ch.cpu_suspended     <= it.cpu_suspended;
        in_ch.cpu_reset_pending <= it.cpu_reset_pending;
        in_ch.cpu_reset_active  <= it.cpu_reset_active;
        in_ch.bus_read_data     <= it.bus_read_data;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.predict_bus_access(it);
        n_sent++;
    endtask

    // Hold the input side quiet until every predicted access is back.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int       pick;
        int       n_ticks;
        bit       full_done;
        full_done = 1'b0;
        sb = new();

        i_rst_n                 <= 1'b0;
        in_ch.valid             <= 1'b0;
        in_ch.action            <= ACT_TICK;
        in_ch.reg_offset        <= '0;
        in_ch.write_data        <= '0;
        in_ch.cpu_suspended     <= 1'b0;
        in_ch.cpu_reset_pending <= 1'b0;
        in_ch.cpu_reset_active  <= 1'b0;
        in_ch.bus_read_data     <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: unhandled offsets, both phase waits, reset priority, restarts.
        send_item(mk_write(5'h00, 8'hff));
        send_item(mk_write(5'h1f, 8'h00));
        send_item(mk_tick(1'b1, 1'b0, 1'b0, 8'h3c));   // idle engine, phase to put
        send_item(mk_write(DMA_REG_OFFSET, 8'hff));
        send_item(mk_tick(1'b1, 1'b0, 1'b0, 8'h11));   // pending on put phase: wait
        send_item(mk_tick(1'b1, 1'b0, 1'b0, 8'hff));   // read ff00
        send_item(mk_tick(1'b0, 1'b0, 1'b0, 8'h77));   // CPU running: no progress
        send_item(mk_tick(1'b1, 1'b0, 1'b0, 8'h22));   // committed on get phase: wait
        send_item(mk_tick(1'b1, 1'b0, 1'b0, 8'h33));   // write ff to 2004
        send_item(mk_tick(1'b1, 1'b0, 1'b0, 8'h00));   // read ff01
        send_item(mk_tick(1'b1, 1'b1, 1'b1, 8'hee));   // reset pending beats active
        send_item(mk_tick(1'b1, 1'b0, 1'b0, 8'h44));   // write 00
        send_item(mk_write(DMA_REG_OFFSET, 8'h00));    // restart while running
        send_item(mk_tick(1'b1, 1'b0, 1'b0, 8'ha5));
        send_item(mk_write(DMA_REG_OFFSET, 8'h80));    // restart from committed
        send_item(mk_tick(1'b1, 1'b0, 1'b0, 8'h5a));
        send_item(mk_tick(1'b1, 1'b0, 1'b1, 8'hc3));   // reset active aborts the copy
        send_item(mk_tick(1'b0, 1'b0, 1'b1, 8'h0f));
        send_item(mk_write(DMA_REG_OFFSET, 8'h5a));
        send_item(mk_tick(1'b0, 1'b1, 1'b0, 8'hf0));
        send_item(mk_tick(1'b1, 1'b0, 1'b0, 8'h96));
        send_item(mk_write(5'h15, 8'h14));              // near miss on the offset
        send_item(mk_write(5'h04, 8'h69));
        drain_results();

        // Random: mostly armed copies with random content, one run of all 256 bytes.
        while (n_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (!full_done && n_sent >= 400) begin
                full_done = 1'b1;
                send_item(mk_write(DMA_REG_OFFSET, 8'($urandom)));
                // 256 reads and writes, a possible phase wait, the serviced tick
                repeat (520) send_item(mk_tick(1'b1, 1'b0, 1'b0, 8'($urandom)));
            end else if (pick < 80) begin
                send_item(mk_write(DMA_REG_OFFSET, 8'($urandom)));
                n_ticks = $urandom_range(1, 40);
                repeat (n_ticks) send_item(rand_tick());
            end else if (pick < 90) begin
                send_item(mk_write(5'($urandom), 8'($urandom)));
            end else begin
                n_ticks = $urandom_range(1, 5);
                repeat (n_ticks) send_item(t_in_item'($urandom));
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
